// ===== rtl/cdt_pkg.sv =====
`default_nettype none

package cdt_pkg;

  // request kinds
  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_LOOKUP  = 2'd1,
    MODE_ADDREF  = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  // result status; code 3 is never produced
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_VOID    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam int unsigned CAP_W       = 11;
  localparam int unsigned CAP_RST_MAX = 1024;
  localparam int unsigned TAG_W       = 48;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CAPWORD_W   = 64 + 64 + TAG_W;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // decision of one request, from the execute logic to the table control
  typedef struct packed {
    status_t status;
    logic    alloc_ok;
    logic    lookup_ok;
    logic    cnt_wr;
    logic    push_free;
  } act_t;

endpackage

`default_nettype wire

// ===== rtl/cdt_ram.sv =====
`default_nettype none

module cdt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/cdt_exec.sv =====
`default_nettype none

module cdt_exec (
  input  wire cdt_pkg::mode_t             mode,
  input  wire logic                       idx_void,
  input  wire logic                       idx_ok,
  input  wire logic                       head_ok,
  input  wire logic                       cap_null,
  input  wire logic [cdt_pkg::CNT_W-1:0]  cnt,
  input  wire logic [63:0]                voff,
  input  wire logic [63:0]                base,
  input  wire logic [63:0]                len,
  output cdt_pkg::act_t                   act,
  output logic      [cdt_pkg::CNT_W-1:0]  cnt_new,
  output logic      [63:0]                lk_base,
  output logic      [63:0]                lk_len
);

  localparam logic [cdt_pkg::CNT_W-1:0] CNT_ONE = 1;

  logic [64:0] diff;
  logic        over;
  logic        cnt_zero;
  logic        cnt_full;

  // borrow of len - voff flags offset beyond length
  assign diff     = {1'b0, len} - {1'b0, voff};
  assign over     = diff[64];
  assign lk_len   = diff[63:0];
  assign lk_base  = base + voff;
  assign cnt_zero = (cnt == '0);
  assign cnt_full = &cnt;
  assign cnt_new  = (mode == cdt_pkg::MODE_ADDREF) ? cnt + 1'b1 : cnt - 1'b1;

  always_comb begin
    act        = '0;
    act.status = cdt_pkg::ST_VOID;
    case (mode)
      cdt_pkg::MODE_ALLOC: begin
        if (!cap_null && head_ok) begin
          act.status   = cdt_pkg::ST_OK;
          act.alloc_ok = 1'b1;
        end
      end
      cdt_pkg::MODE_LOOKUP: begin
        if (!idx_void && idx_ok && !cnt_zero && !over) begin
          act.status    = cdt_pkg::ST_OK;
          act.lookup_ok = 1'b1;
        end
      end
      cdt_pkg::MODE_ADDREF: begin
        if (idx_void) begin
          act.status = cdt_pkg::ST_VOID;
        end else if (!idx_ok || cnt_zero || cnt_full) begin
          act.status = cdt_pkg::ST_REFUSED;
        end else begin
          act.status = cdt_pkg::ST_OK;
          act.cnt_wr = 1'b1;
        end
      end
      cdt_pkg::MODE_RELEASE: begin
        if (idx_void) begin
          act.status = cdt_pkg::ST_VOID;
        end else if (!idx_ok || cnt_zero) begin
          act.status = cdt_pkg::ST_REFUSED;
        end else begin
          act.status    = cdt_pkg::ST_OK;
          act.cnt_wr    = 1'b1;
          act.push_free = (cnt == CNT_ONE);
        end
      end
      default: begin
        act.status = cdt_pkg::ST_VOID;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/capability_descriptor_table_unit.sv =====
`default_nettype none

// Capability descriptor table. Each entry holds a capability (base, length,
// generation, permissions, seal type), a reference count and a free-list
// link. An item is one request: alloc, lookup, addref or release, and it
// yields exactly one result item carrying status, the allocated index, the
// looked-up capability and the live entry count. The accept cycle issues
// the synchronous read of both entry memories; the execute state then
// decides, writes the entry back and loads the output register. A new item
// is accepted only after the previous one has left the execute state. A
// held result only delays the execute cycle of the following item; the next
// item is still accepted. Reset and a capacity write rebuild the table with
// no clearing pass: a fill mark separates entries handed out since the
// rebuild (whose count and link live in memory) from untouched ones, which
// read as count zero and chain to the next index. Capacity writes whose
// low 11 bits lie outside 1..MAX_ENTRIES are dropped. Fields of a lookup
// that hits an entry never allocated since power-up are unspecified, but
// a lookup only reads entries with a live count, so that does not arise in
// use. The user must write configuration only while no item is in flight;
// the block itself does not enforce it.
module capability_descriptor_table_unit #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_entry_index,
  input  wire logic [63:0] in_view_offset,
  input  wire logic [7:0]  in_view_perms,
  input  wire logic [63:0] in_cap_base,
  input  wire logic [63:0] in_cap_length,
  input  wire logic [31:0] in_cap_generation,
  input  wire logic [7:0]  in_cap_perms,
  input  wire logic [7:0]  in_cap_type,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [9:0]       out_given_index,
  output logic [63:0]      out_base,
  output logic [63:0]      out_length,
  output logic [31:0]      out_generation,
  output logic [7:0]       out_perms,
  output logic [7:0]       out_type,
  output logic [10:0]      out_live_count,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IW     = $clog2(MAX_ENTRIES);   // entry address bits
  localparam int unsigned PTRW   = IW + 1;                // pointer incl. end mark
  localparam int unsigned PW     = (PTRW > cdt_pkg::CAP_W) ? PTRW : cdt_pkg::CAP_W;
  localparam int unsigned LINK_W = cdt_pkg::CNT_W + PTRW;
  localparam logic [PTRW-1:0] END_MARK = PTRW'(MAX_ENTRIES);
  localparam logic [cdt_pkg::CAP_W-1:0] CAP_RST =
    cdt_pkg::CAP_W'((MAX_ENTRIES < cdt_pkg::CAP_RST_MAX) ? MAX_ENTRIES
                                                          : cdt_pkg::CAP_RST_MAX);
  localparam logic [cdt_pkg::CNT_W-1:0] CNT_ONE = 1;

  // ---------------------------------------------------------------- control
  cdt_pkg::state_t state_r, state_nxt;
  logic            in_acc;
  logic            exec_fire;

  logic [cdt_pkg::CAP_W-1:0] capacity_r, capacity_nxt;
  logic [PTRW-1:0]           avail_head_r, avail_head_nxt;
  logic [PTRW-1:0]           fill_r, fill_nxt;      // entries at or above are untouched
  logic [10:0]               used_r, used_nxt;
  logic [10:0]               used_after;
  logic                      out_valid_r, out_valid_nxt;

  // ------------------------------------------------------- latched request
  cdt_pkg::mode_t mode_r;
  logic [31:0]    idx_r;
  logic [63:0]    voff_r;
  logic [7:0]     vperm_r;
  logic [63:0]    cbase_r;
  logic [63:0]    clen_r;
  logic [31:0]    cgen_r;
  logic [7:0]     cperm_r;
  logic [7:0]     ctype_r;

  // ---------------------------------------------------------- result regs
  cdt_pkg::status_t st_r;
  logic [9:0]       given_r;
  logic [63:0]      obase_r;
  logic [63:0]      olen_r;
  logic [31:0]      ogen_r;
  logic [7:0]       operm_r;
  logic [7:0]       otype_r;
  logic [10:0]      live_r;

  // --------------------------------------------------------------- memories
  logic [IW-1:0]                  rd_addr;
  logic [IW-1:0]                  wr_addr;
  logic                           cap_we;
  logic [cdt_pkg::CAPWORD_W-1:0]  cap_wdata;
  logic [cdt_pkg::CAPWORD_W-1:0]  cap_rdata;
  logic                           link_we;
  logic [LINK_W-1:0]              link_wdata;
  logic [LINK_W-1:0]              link_rdata;

  logic [63:0]               rd_base;
  logic [63:0]               rd_len;
  logic [cdt_pkg::TAG_W-1:0] rd_tag;
  logic [cdt_pkg::CNT_W-1:0] rd_cnt;
  logic [PTRW-1:0]           rd_next;

  // ------------------------------------------------------------ decisions
  logic [IW-1:0]             idx_low;
  logic                      idx_void;
  logic                      idx_ok;
  logic                      idx_filled;
  logic                      head_ok;
  logic                      head_fresh;
  logic [PTRW-1:0]           head_inc;
  logic [PTRW-1:0]           pop_next;
  logic [cdt_pkg::CNT_W-1:0] cnt_eff;
  cdt_pkg::act_t             act;
  logic [cdt_pkg::CNT_W-1:0] cnt_new;
  logic [63:0]               lk_base;
  logic [63:0]               lk_len;

  // ------------------------------------------------------------ config port
  logic                      cfg_wr;
  logic [cdt_pkg::CAP_W-1:0] cfg_val;
  logic                      rebuild;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == cdt_pkg::REG_CAPACITY);
  assign cfg_val = pwdata[cdt_pkg::CAP_W-1:0];
  // only a capacity in 1..MAX_ENTRIES takes effect
  assign rebuild = cfg_wr && (cfg_val != '0) && (32'(cfg_val) <= 32'(MAX_ENTRIES));
  assign prdata  = (paddr[2] == cdt_pkg::REG_CAPACITY) ? 32'(capacity_r) : 32'd0;

  // ----------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdt_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = cdt_pkg::S_EXEC;
        end
      end
      cdt_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_nxt = cdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cdt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    exec_fire = 1'b0;
    case (state_r)
      cdt_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      cdt_pkg::S_EXEC: begin
        // finish once the output slot is free or draining this cycle
        exec_fire = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  // -------------------------------------------------------- request latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= cdt_pkg::mode_t'(in_mode);
      idx_r   <= in_entry_index;
      voff_r  <= in_view_offset;
      vperm_r <= in_view_perms;
      cbase_r <= in_cap_base;
      clen_r  <= in_cap_length;
      cgen_r  <= in_cap_generation;
      cperm_r <= in_cap_perms;
      ctype_r <= in_cap_type;
    end
  end

  // read issued on the accept edge: alloc reads the free-list head entry
  assign rd_addr = (cdt_pkg::mode_t'(in_mode) == cdt_pkg::MODE_ALLOC) ?
                   avail_head_r[IW-1:0] : in_entry_index[IW-1:0];

  cdt_ram #(
    .WIDTH (cdt_pkg::CAPWORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_cap_ram (
    .clk   (clk),
    .we    (cap_we),
    .waddr (wr_addr),
    .wdata (cap_wdata),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (cap_rdata)
  );

  cdt_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (wr_addr),
    .wdata (link_wdata),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  // capability word: {base, length, type, perms, generation}
  assign rd_base = cap_rdata[cdt_pkg::CAPWORD_W-1 -: 64];
  assign rd_len  = cap_rdata[cdt_pkg::TAG_W +: 64];
  assign rd_tag  = cap_rdata[cdt_pkg::TAG_W-1:0];
  // link word: {count, next}
  assign rd_cnt  = link_rdata[LINK_W-1 -: cdt_pkg::CNT_W];
  assign rd_next = link_rdata[PTRW-1:0];

  // ------------------------------------------------------- execute cycle
  assign idx_low    = idx_r[IW-1:0];
  assign idx_void   = &idx_r;
  assign idx_ok     = idx_r < 32'(capacity_r);
  assign idx_filled = {1'b0, idx_low} < fill_r;
  // untouched entries have count zero
  assign cnt_eff    = (idx_ok && idx_filled) ? rd_cnt : '0;

  assign head_ok    = (avail_head_r != END_MARK) && (PW'(avail_head_r) < PW'(capacity_r));
  assign head_fresh = (avail_head_r == fill_r);
  assign head_inc   = avail_head_r + 1'b1;
  // an untouched head chains to the next index, else follow the stored link
  assign pop_next   = head_fresh ?
                      ((PW'(head_inc) < PW'(capacity_r)) ? head_inc : END_MARK) :
                      rd_next;

  cdt_exec u_exec (
    .mode      (mode_r),
    .idx_void  (idx_void),
    .idx_ok    (idx_ok),
    .head_ok   (head_ok),
    .cap_null  (&cbase_r),
    .cnt       (cnt_eff),
    .voff      (voff_r),
    .base      (rd_base),
    .len       (rd_len),
    .act       (act),
    .cnt_new   (cnt_new),
    .lk_base   (lk_base),
    .lk_len    (lk_len)
  );

  assign wr_addr   = act.alloc_ok ? avail_head_r[IW-1:0] : idx_low;
  assign cap_we    = exec_fire && act.alloc_ok;
  assign cap_wdata = {cbase_r, clen_r, ctype_r, cperm_r, cgen_r};
  assign link_we   = exec_fire && (act.alloc_ok || act.cnt_wr);
  assign link_wdata = act.alloc_ok ? {CNT_ONE, rd_next} :
                      {cnt_new, (act.push_free ? avail_head_r : rd_next)};

  always_comb begin
    used_after = used_r;
    if (act.alloc_ok) begin
      used_after = used_r + 1'b1;
    end else if (act.push_free) begin
      used_after = used_r - 1'b1;
    end
  end

  always_comb begin
    capacity_nxt   = capacity_r;
    avail_head_nxt = avail_head_r;
    fill_nxt       = fill_r;
    used_nxt       = used_r;
    if (exec_fire) begin
      used_nxt = used_after;
      if (act.alloc_ok) begin
        avail_head_nxt = pop_next;
        if (head_fresh) begin
          fill_nxt = head_inc;
        end
      end else if (act.push_free) begin
        avail_head_nxt = {1'b0, idx_low};
      end
    end
    if (rebuild) begin
      capacity_nxt   = cfg_val;
      avail_head_nxt = '0;
      fill_nxt       = '0;
      used_nxt       = '0;
    end
  end

  assign out_valid_nxt = exec_fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cdt_pkg::S_IDLE;
      capacity_r   <= CAP_RST;
      avail_head_r <= '0;
      fill_r       <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      capacity_r   <= capacity_nxt;
      avail_head_r <= avail_head_nxt;
      fill_r       <= fill_nxt;
      used_r       <= used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      st_r    <= act.status;
      given_r <= act.alloc_ok ? 10'(avail_head_r) : 10'd0;
      obase_r <= act.lookup_ok ? lk_base : 64'd0;
      olen_r  <= act.lookup_ok ? lk_len : 64'd0;
      ogen_r  <= act.lookup_ok ? rd_tag[31:0] : 32'd0;
      otype_r <= act.lookup_ok ? rd_tag[47:40] : 8'd0;
      live_r  <= used_after;
      if (act.alloc_ok) begin
        operm_r <= cperm_r;
      end else if (act.lookup_ok) begin
        operm_r <= rd_tag[39:32] & vperm_r;
      end else begin
        operm_r <= 8'd0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = st_r;
  assign out_given_index = given_r;
  assign out_base        = obase_r;
  assign out_length      = olen_r;
  assign out_generation  = ogen_r;
  assign out_perms       = operm_r;
  assign out_type        = otype_r;
  assign out_live_count  = live_r;

  // ------------------------------------------------------------ assertions
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == cdt_pkg::S_EXEC))
    else $error("result raised without an execute cycle");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= capacity_r)
    else $error("live count exceeds capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(fill_r) <= PW'(capacity_r))
    else $error("fill mark beyond capacity");

  a_release_push: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && act.push_free && !rebuild) |=> (avail_head_r[IW-1:0] == $past(idx_low)))
    else $error("released entry not at free-list head");

endmodule

`default_nettype wire

// ===== dv/capability_descriptor_table_unit_test.sv =====
`timescale 1ns / 100ps

// Request/response test of the capability table. A shadow copy of the table
// (stores, counts, free-list links, head, live count, capacity) is updated
// at every accepted item and yields the reply that the block must send back.
// Replies are checked in order against that queue.
module capability_descriptor_table_unit_test;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned END_MARK    = MAX_ENTRIES;   // free-list terminator
  localparam int unsigned FULL_SIZE   = 160;           // table size for the fill test
  localparam logic [2:0]  CAPACITY_ADDR = {cdt_pkg::REG_CAPACITY, 2'b00};
  localparam logic [31:0] VOID_INDEX  = '1;
  localparam logic [63:0] VOID_BASE   = '1;

  typedef struct {
    cdt_pkg::mode_t mode;
    logic [31:0]    index;
    logic [63:0]    offset;
    logic [7:0]     view_perms;
    logic [63:0]    base;
    logic [63:0]    length;
    logic [31:0]    generation;
    logic [7:0]     perms;
    logic [7:0]     seal;
  } request_t;

  typedef struct {
    cdt_pkg::status_t status;
    logic [9:0]       given_index;
    logic [63:0]      base;
    logic [63:0]      length;
    logic [31:0]      generation;
    logic [7:0]       perms;
    logic [7:0]       seal;
    logic [10:0]      live;
  } reply_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n;
  always #2 clk = ~clk;

  // request channel
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [31:0] in_entry_index;
  logic [63:0] in_view_offset;
  logic [7:0]  in_view_perms;
  logic [63:0] in_cap_base;
  logic [63:0] in_cap_length;
  logic [31:0] in_cap_generation;
  logic [7:0]  in_cap_perms;
  logic [7:0]  in_cap_type;

  // reply channel
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [9:0]  out_given_index;
  logic [63:0] out_base;
  logic [63:0] out_length;
  logic [31:0] out_generation;
  logic [7:0]  out_perms;
  logic [7:0]  out_type;
  logic [10:0] out_live_count;

  // register port
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  capability_descriptor_table_unit #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_entry_index    (in_entry_index),
    .in_view_offset    (in_view_offset),
    .in_view_perms     (in_view_perms),
    .in_cap_base       (in_cap_base),
    .in_cap_length     (in_cap_length),
    .in_cap_generation (in_cap_generation),
    .in_cap_perms      (in_cap_perms),
    .in_cap_type       (in_cap_type),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_given_index   (out_given_index),
    .out_base          (out_base),
    .out_length        (out_length),
    .out_generation    (out_generation),
    .out_perms         (out_perms),
    .out_type          (out_type),
    .out_live_count    (out_live_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // shadow table; entry contents only read once a count says they were written
  logic [63:0] shadow_base   [MAX_ENTRIES];
  logic [63:0] shadow_length [MAX_ENTRIES];
  logic [31:0] shadow_gen    [MAX_ENTRIES];
  logic [7:0]  shadow_perms  [MAX_ENTRIES];
  logic [7:0]  shadow_seal   [MAX_ENTRIES];
  logic [31:0] shadow_refs   [MAX_ENTRIES];
  int unsigned shadow_link   [MAX_ENTRIES];
  int unsigned avail_head;
  int unsigned live_entries;
  int unsigned capacity;

  reply_t replies_due [$];
  int unsigned error_count = 0;

  // idling switches, flipped per test to get stretches without gaps
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;

  //--------------------------------------------------------------------------
  // shadow table
  //--------------------------------------------------------------------------

  // empty the table: counts cleared, chain 0 -> 1 -> ... -> capacity-1 -> end
  function automatic void rebuild_free_list();
    for (int unsigned i = 0; i < MAX_ENTRIES; i++) begin
      shadow_refs[i] = '0;
      shadow_link[i] = (i + 1 < capacity) ? i + 1 : END_MARK;
    end
    avail_head   = 0;
    live_entries = 0;
  endfunction

  // bits above the register width are dropped; out-of-range values are ignored
  function automatic void apply_capacity_write(logic [31:0] value);
    int unsigned v;
    v = 32'(value[10:0]);
    if (v != 0 && v <= MAX_ENTRIES) begin
      capacity = v;
      rebuild_free_list();
    end
  endfunction

  function automatic reply_t predict_reply(request_t r);
    reply_t      y;
    int unsigned e;
    y.status      = cdt_pkg::ST_VOID;
    y.given_index = '0;
    y.base        = '0;
    y.length      = '0;
    y.generation  = '0;
    y.perms       = '0;
    y.seal        = '0;
    e = r.index;
    if (r.mode == cdt_pkg::MODE_ALLOC) begin
      // void capability or exhausted free list leaves everything untouched
      if (r.base != VOID_BASE && avail_head < capacity && avail_head < END_MARK) begin
        e = avail_head;
        avail_head       = shadow_link[e];
        shadow_base[e]   = r.base;
        shadow_length[e] = r.length;
        shadow_gen[e]    = r.generation;
        shadow_perms[e]  = r.perms;
        shadow_seal[e]   = r.seal;
        shadow_refs[e]   = 32'd1;
        live_entries++;
        y.status      = cdt_pkg::ST_OK;
        y.given_index = 10'(e);
        y.perms       = r.perms;
      end
    end else if (r.index == VOID_INDEX) begin
      y.status = cdt_pkg::ST_VOID;
    end else if (r.mode == cdt_pkg::MODE_LOOKUP) begin
      if (e < capacity && shadow_refs[e] != 0 && r.offset <= shadow_length[e]) begin
        y.status     = cdt_pkg::ST_OK;
        y.base       = shadow_base[e] + r.offset;   // wraps modulo 2^64
        y.length     = shadow_length[e] - r.offset;
        y.generation = shadow_gen[e];
        y.perms      = shadow_perms[e] & r.view_perms;
        y.seal       = shadow_seal[e];
      end
    end else if (e >= capacity || shadow_refs[e] == 0) begin
      y.status = cdt_pkg::ST_REFUSED;
    end else if (r.mode == cdt_pkg::MODE_ADDREF) begin
      if (shadow_refs[e] == '1) begin
        y.status = cdt_pkg::ST_REFUSED;              // saturated
      end else begin
        shadow_refs[e]++;
        y.status = cdt_pkg::ST_OK;
      end
    end else begin
      shadow_refs[e]--;
      if (shadow_refs[e] == 0) begin
        shadow_link[e] = avail_head;                 // back on the head of the list
        avail_head     = e;
        live_entries--;
      end
      y.status = cdt_pkg::ST_OK;
    end
    y.live = 11'(live_entries);
    return y;
  endfunction

  //--------------------------------------------------------------------------
  // stimulus helpers
  //--------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // a live index below capacity, or the void handle when the table is empty
  function automatic logic [31:0] pick_live_index();
    int unsigned start;
    if (live_entries == 0) return VOID_INDEX;
    start = $urandom_range(0, capacity - 1);
    for (int unsigned k = 0; k < capacity; k++) begin
      if (shadow_refs[(start + k) % capacity] != 0) return (start + k) % capacity;
    end
    return VOID_INDEX;
  endfunction

  // mostly well-formed traffic on live handles, with some noise mixed in
  function automatic request_t random_request();
    request_t    r;
    int unsigned roll;
    logic [63:0] span;
    r.index      = $urandom;
    r.offset     = rand64();
    r.view_perms = 8'($urandom);
    r.base       = rand64();
    r.length     = rand64();
    r.generation = $urandom;
    r.perms      = 8'($urandom);
    r.seal       = 8'($urandom);

    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      r.mode = cdt_pkg::MODE_ALLOC;
    end else if (roll < 60) begin
      r.mode = cdt_pkg::MODE_LOOKUP;
    end else if (roll < 75) begin
      r.mode = cdt_pkg::MODE_ADDREF;
    end else begin
      r.mode = cdt_pkg::MODE_RELEASE;
    end

    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      r.length = $urandom_range(0, 255);
    end else if (roll < 35) begin
      r.length = '1;
    end
    if ($urandom_range(0, 99) < 4) r.base = VOID_BASE;

    roll = $urandom_range(0, 99);
    if (roll < 78) begin
      r.index = pick_live_index();
    end else if (roll < 90) begin
      r.index = $urandom_range(0, capacity - 1);
    end else if (roll < 95) begin
      r.index = VOID_INDEX;
    end

    // lookups on live entries: inside, at and just past the stored length
    if (r.mode == cdt_pkg::MODE_LOOKUP && r.index < capacity && shadow_refs[r.index] != 0) begin
      span = shadow_length[r.index];
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        r.offset = (span == '1) ? rand64() : rand64() % (span + 1);
      end else if (roll < 70) begin
        r.offset = span;
      end else if (roll < 85 && span != '1) begin
        r.offset = span + 1;
      end
    end
    return r;
  endfunction

  // one item: optional gap, then hold it until accepted, then predict
  task automatic send_request(request_t r);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode           = r.mode;
    in_entry_index    = r.index;
    in_view_offset    = r.offset;
    in_view_perms     = r.view_perms;
    in_cap_base       = r.base;
    in_cap_length     = r.length;
    in_cap_generation = r.generation;
    in_cap_perms      = r.perms;
    in_cap_type       = r.seal;
    in_valid          = 1'b1;
    do @(posedge clk); while (in_stall);
    replies_due.push_back(predict_reply(r));
  endtask

  task automatic do_alloc(logic [63:0] base, logic [63:0] length, logic [31:0] generation,
                          logic [7:0] perms, logic [7:0] seal);
    request_t r;
    r            = random_request();
    r.mode       = cdt_pkg::MODE_ALLOC;
    r.base       = base;
    r.length     = length;
    r.generation = generation;
    r.perms      = perms;
    r.seal       = seal;
    send_request(r);
  endtask

  task automatic do_lookup(logic [31:0] index, logic [63:0] offset, logic [7:0] mask);
    request_t r;
    r            = random_request();
    r.mode       = cdt_pkg::MODE_LOOKUP;
    r.index      = index;
    r.offset     = offset;
    r.view_perms = mask;
    send_request(r);
  endtask

  // addref or release
  task automatic do_handle(cdt_pkg::mode_t mode, logic [31:0] index);
    request_t r;
    r       = random_request();
    r.mode  = mode;
    r.index = index;
    send_request(r);
  endtask

  // stop sending and wait until every reply is in, so the block is idle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = CAPACITY_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (write) apply_capacity_write(wdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_capacity_readback();
    logic [31:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    check_field("capacity readback", 64'(rdata), 64'(capacity));
  endtask

  task automatic set_capacity(logic [31:0] value);
    logic [31:0] unused;
    drain();
    apb_transfer(1'b1, value, unused);
    check_capacity_readback();
  endtask

  //--------------------------------------------------------------------------
  // reply checking
  //--------------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  // takes replies in order; after each one may stall the reply channel when receiver gaps are on
  initial begin : reply_checker
    int unsigned hold;
    reply_t      want;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("reply with nothing pending", 64'(out_status), '0);
        end else begin
          want = replies_due.pop_front();
          check_field("status",      64'(out_status),      64'(want.status));
          check_field("given_index", 64'(out_given_index), 64'(want.given_index));
          check_field("base",        out_base,             want.base);
          check_field("length",      out_length,           want.length);
          check_field("generation",  64'(out_generation),  64'(want.generation));
          check_field("perms",       64'(out_perms),       64'(want.perms));
          check_field("type",        64'(out_type),        64'(want.seal));
          check_field("live_count",  64'(out_live_count),  64'(want.live));
        end
        hold = receiver_gaps ? $urandom_range(0, 7) : 0;
        if (hold > 0) begin
          @(negedge clk);
          out_stall = 1'b1;
          repeat (hold) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // tests
  //--------------------------------------------------------------------------

  // empty table at reset size: every handle is free, out of range or void
  task automatic test_reset_state();
    check_capacity_readback();
    do_lookup(0, 0, 8'hFF);
    do_handle(cdt_pkg::MODE_ADDREF, 0);
    do_handle(cdt_pkg::MODE_RELEASE, MAX_ENTRIES - 1);
    do_lookup(MAX_ENTRIES, 0, 8'hFF);
    do_handle(cdt_pkg::MODE_ADDREF, MAX_ENTRIES);
    do_lookup(VOID_INDEX, 0, 8'hFF);
    do_handle(cdt_pkg::MODE_ADDREF, VOID_INDEX);
    do_handle(cdt_pkg::MODE_RELEASE, VOID_INDEX);
  endtask

  // every operation, with corner cases, on a three-entry table
  task automatic test_directed_ops();
    set_capacity(3);
    do_alloc(VOID_BASE, 64'd16, 32'd1, 8'h01, 8'h00);          // void capability
    do_alloc('0, '0, '0, '0, '0);                              // entry 0, all zero
    do_alloc(VOID_BASE - 1, '1, '1, 8'hFF, 8'hFF);             // entry 1, all ones
    do_lookup(1, 0, 8'hFF);
    do_lookup(1, '1, 8'h5A);         // base wraps, offset equals length
    do_lookup(0, 0, 8'hFF);          // zero-length region, offset at length
    do_lookup(0, 1, 8'hFF);          // offset past length
    do_alloc(64'h8000_0000_0000_0000, 64'd100, 32'h8000_0001, 8'hA5, 8'h3C);
    do_alloc(64'd4096, 64'd8, 32'd7, 8'h0F, 8'h01);            // table full
    do_handle(cdt_pkg::MODE_ADDREF, 0);
    do_handle(cdt_pkg::MODE_RELEASE, 0);
    do_handle(cdt_pkg::MODE_RELEASE, 0);      // count hits zero, entry freed
    do_lookup(0, 0, 8'hFF);          // free entry
    do_handle(cdt_pkg::MODE_RELEASE, 0);
    do_handle(cdt_pkg::MODE_ADDREF, 0);
    do_alloc(64'd64, 64'd32, 32'd9, 8'h77, 8'h80);             // reuses entry 0
    do_lookup(3, 0, 8'hFF);          // at capacity
    do_handle(cdt_pkg::MODE_ADDREF, 3);
    do_handle(cdt_pkg::MODE_RELEASE, 3);
    do_handle(cdt_pkg::MODE_RELEASE, 2);
    do_handle(cdt_pkg::MODE_RELEASE, 1);
  endtask

  // bad writes keep the table; good ones (upper bits ignored) rebuild it
  task automatic test_capacity_writes();
    set_capacity(4);
    do_alloc(64'd100, 64'd50, 32'd1, 8'hC3, 8'h11);
    do_alloc(64'd200, 64'd60, 32'd2, 8'h3C, 8'h22);
    set_capacity(0);
    set_capacity(MAX_ENTRIES + 1);
    set_capacity('1);
    do_lookup(1, 10, 8'hFF);
    do_alloc(64'd300, 64'd70, 32'd3, 8'h99, 8'h33);
    set_capacity(32'hFFFF_F801);     // capacity 1
    do_lookup(0, 0, 8'hFF);          // cleared by the rebuild
    do_alloc(64'd400, 64'd80, 32'd4, 8'h66, 8'h44);
    do_alloc(64'd500, 64'd90, 32'd5, 8'h55, 8'h55);            // full at one entry
    do_handle(cdt_pkg::MODE_RELEASE, 0);
    do_alloc(64'd600, 64'd99, 32'd6, 8'h44, 8'h66);
  endtask

  // fill a mid-size table back to back, overflow it and recycle entries.
  // A saturated count needs 2^32 - 2 addrefs and is left out.
  task automatic test_full_table();
    request_t r;
    set_capacity(FULL_SIZE);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    repeat (FULL_SIZE) begin
      r      = random_request();
      r.mode = cdt_pkg::MODE_ALLOC;
      r.base = rand64() >> 1;
      send_request(r);
    end
    do_alloc(64'd1, 64'd1, 32'd1, 8'h01, 8'h01);               // table full
    do_lookup(FULL_SIZE - 1, 0, 8'hFF);
    do_handle(cdt_pkg::MODE_ADDREF, FULL_SIZE - 1);
    do_handle(cdt_pkg::MODE_RELEASE, FULL_SIZE - 1);
    do_handle(cdt_pkg::MODE_RELEASE, FULL_SIZE - 1);
    do_handle(cdt_pkg::MODE_RELEASE, FULL_SIZE / 2);
    do_lookup(FULL_SIZE, 0, 8'hFF);
    do_alloc(rand64() >> 1, rand64(), $urandom, 8'($urandom), 8'($urandom));
    do_alloc(rand64() >> 1, rand64(), $urandom, 8'($urandom), 8'($urandom));
    do_alloc(rand64() >> 1, rand64(), $urandom, 8'($urandom), 8'($urandom));
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // random traffic over several table sizes, idling on and off per phase
  task automatic test_random_traffic();
    int unsigned sizes [5] = '{8, 2, 64, 5, MAX_ENTRIES};
    for (int unsigned p = 0; p < 5; p++) begin
      set_capacity(sizes[p]);
      sender_gaps   = (p != 1);
      receiver_gaps = (p != 3);
      repeat (40) send_request(random_request());
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  //--------------------------------------------------------------------------
  // main sequence
  //--------------------------------------------------------------------------

  initial begin : test_sequence
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_mode           = '0;
    in_entry_index    = '0;
    in_view_offset    = '0;
    in_view_perms     = '0;
    in_cap_base       = '0;
    in_cap_length     = '0;
    in_cap_generation = '0;
    in_cap_perms      = '0;
    in_cap_type       = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;

    // shadow matches the block's reset state
    for (int unsigned i = 0; i < MAX_ENTRIES; i++) begin
      shadow_base[i]   = '0;
      shadow_length[i] = '0;
      shadow_gen[i]    = '0;
      shadow_perms[i]  = '0;
      shadow_seal[i]   = '0;
    end
    capacity = MAX_ENTRIES;
    rebuild_free_list();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed_ops();
    test_capacity_writes();
    test_full_table();
    test_random_traffic();

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard: far beyond the slowest passing run
  initial begin : watchdog
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
